/* design/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg
// shared types, field widths and helpers for the typed slot table
// ----------------------------------------------------------------------------
package stc_pkg;

    // table geometry and field widths, fixed by the stream formats
    localparam int SLOTS          = 16;
    localparam int IDX_BITS       = $clog2(SLOTS);
    localparam int MODE_BITS      = 3;
    localparam int TYPE_BITS      = 8;
    localparam int INDEX_BITS     = 4;
    localparam int AMOUNT_IN_BITS = 17;
    localparam int AMOUNT_BITS    = 16;
    localparam int COUNT_BITS     = $clog2(SLOTS + 1);
    localparam int SUM_BITS       = AMOUNT_IN_BITS + 1;

    localparam logic signed [SUM_BITS-1:0] AMOUNT_MAX =
        {{(SUM_BITS - AMOUNT_BITS){1'b0}}, {AMOUNT_BITS{1'b1}}};

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ADD    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_UPDATE = 3'd2,
        MODE_FIND   = 3'd3,
        MODE_CHECK  = 3'd4,
        MODE_READ   = 3'd5,
        MODE_CLEAR  = 3'd6
    } mode_t;

    typedef struct packed {
        mode_t                             mode;
        logic [TYPE_BITS-1:0]              item_type;
        logic [INDEX_BITS-1:0]             slot_index;
        logic signed [AMOUNT_IN_BITS-1:0]  amount;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic [INDEX_BITS-1:0]   slot_found;
        logic [TYPE_BITS-1:0]    slot_type;
        logic [AMOUNT_BITS-1:0]  slot_amount;
        logic                    slot_full;
        logic [COUNT_BITS-1:0]   filled_count;
    } res_t;

    typedef struct packed {
        logic [TYPE_BITS-1:0]    held_type;
        logic [AMOUNT_BITS-1:0]  held_amount;
    } entry_t;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_BITS-1:0]  rd_addr;
        logic                 wr_en;
        logic [IDX_BITS-1:0]  wr_addr;
        entry_t               wr_data;
    } mem_req_t;

    // clamp a signed sum into the stored amount range
    function automatic logic [AMOUNT_BITS-1:0] sat_amount(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [AMOUNT_BITS-1:0] r;
        if (v[SUM_BITS-1]) begin
            r = '0;
        end
        else if (v > AMOUNT_MAX) begin
            r = {AMOUNT_BITS{1'b1}};
        end
        else begin
            r = v[AMOUNT_BITS-1:0];
        end
        return r;
    endfunction

    // sign-extend an input amount to the sum width
    function automatic logic signed [SUM_BITS-1:0] ext_amount(
        input logic signed [AMOUNT_IN_BITS-1:0] a
    );
        return {{(SUM_BITS - AMOUNT_IN_BITS){a[AMOUNT_IN_BITS-1]}}, a};
    endfunction

    // zero-extend a stored amount to the sum width
    function automatic logic signed [SUM_BITS-1:0] ext_held(
        input logic [AMOUNT_BITS-1:0] a
    );
        return {{(SUM_BITS - AMOUNT_BITS){1'b0}}, a};
    endfunction

endpackage

/* design/stc_mem.sv */
// ----------------------------------------------------------------------------
// stc_mem
// slot contents memory, one write and one registered read port
// ----------------------------------------------------------------------------
module stc_mem
    import stc_pkg::*;
(
    input  logic      clk,
    input  mem_req_t  mem_req,
    output entry_t    rd_data
);

    entry_t slot_mem_reg [SLOTS];
    entry_t rd_data_reg;

    // contents are undefined until written, so no reset
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            slot_mem_reg[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= slot_mem_reg[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/stc_ctrl.sv */
// ----------------------------------------------------------------------------
// stc_ctrl
// operation sequencer: occupancy bits, fill count, read-modify-write
// ----------------------------------------------------------------------------
module stc_ctrl
    import stc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_t      req,
    input  logic      out_free,
    output logic      res_valid,
    output res_t      res,
    output mem_req_t  mem_req,
    input  entry_t    rd_data
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                 state_reg,    state_next;
    logic [SLOTS-1:0]       occupied_reg, occupied_next;
    logic [COUNT_BITS-1:0]  count_reg,    count_next;
    logic [IDX_BITS-1:0]    scan_reg,     scan_next;
    req_t                   req_reg,      req_next;

    logic [IDX_BITS-1:0]        free_idx;
    logic [IDX_BITS-1:0]        idx;
    logic                       idx_ok;
    logic signed [SUM_BITS-1:0] upd_sum;
    logic                       match;
    logic                       done;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occupied_reg[i])
            begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign idx    = req_reg.slot_index[IDX_BITS-1:0];
    assign idx_ok = {1'b0, req_reg.slot_index} < (INDEX_BITS + 1)'(SLOTS);

    assign upd_sum = ext_held(rd_data.held_amount) + ext_amount(req_reg.amount);

    assign match = occupied_reg[scan_reg]
                 && (rd_data.held_type == req_reg.item_type)
                 && ((req_reg.mode == MODE_FIND)
                     || (ext_held(rd_data.held_amount) >= ext_amount(req_reg.amount)));

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        occupied_next = occupied_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        req_next      = req_reg;
        mem_req       = '0;
        res           = '0;
        res_valid     = 1'b0;
        done          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next       = req;
                    scan_next      = '0;
                    state_next     = ST_EXEC;
                    mem_req.rd_en  = 1'b1;
                    if (req.mode inside {MODE_FIND, MODE_CHECK})
                    begin
                        mem_req.rd_addr = '0;
                    end
                    else
                    begin
                        mem_req.rd_addr = req.slot_index[IDX_BITS-1:0];
                    end
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    done = 1'b1;
                    case (req_reg.mode)
                        MODE_ADD:
                        begin
                            if (count_reg < COUNT_BITS'(SLOTS))
                            begin
                                mem_req.wr_en                 = 1'b1;
                                mem_req.wr_addr               = free_idx;
                                mem_req.wr_data.held_type     = req_reg.item_type;
                                mem_req.wr_data.held_amount   =
                                    sat_amount(ext_amount(req_reg.amount));
                                occupied_next[free_idx]       = 1'b1;
                                count_next                    = count_reg + 1'b1;
                                res.ok                        = 1'b1;
                                res.slot_found                = INDEX_BITS'(free_idx);
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (idx_ok && occupied_reg[idx])
                            begin
                                occupied_next[idx] = 1'b0;
                                count_next         = count_reg - 1'b1;
                                res.ok             = 1'b1;
                            end
                        end
                        MODE_UPDATE:
                        begin
                            if (idx_ok && occupied_reg[idx])
                            begin
                                res.ok = 1'b1;
                                if (upd_sum[SUM_BITS-1] || (upd_sum == '0))
                                begin
                                    occupied_next[idx] = 1'b0;
                                    count_next         = count_reg - 1'b1;
                                end
                                else
                                begin
                                    mem_req.wr_en               = 1'b1;
                                    mem_req.wr_addr             = idx;
                                    mem_req.wr_data.held_type   = rd_data.held_type;
                                    mem_req.wr_data.held_amount = sat_amount(upd_sum);
                                    res.slot_type               = rd_data.held_type;
                                    res.slot_amount             = sat_amount(upd_sum);
                                    res.slot_full               = 1'b1;
                                end
                            end
                        end
                        MODE_FIND, MODE_CHECK:
                        begin
                            if (match)
                            begin
                                res.ok         = 1'b1;
                                res.slot_found = INDEX_BITS'(scan_reg);
                            end
                            else if (scan_reg != IDX_BITS'(SLOTS - 1))
                            begin
                                // next slot: one memory read per cycle while the output register is free
                                done            = 1'b0;
                                scan_next       = scan_reg + 1'b1;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = scan_reg + 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            if (idx_ok)
                            begin
                                res.ok = 1'b1;
                                if (occupied_reg[idx])
                                begin
                                    res.slot_type   = rd_data.held_type;
                                    res.slot_amount = rd_data.held_amount;
                                    res.slot_full   = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            occupied_next = '0;
                            count_next    = '0;
                            res.ok        = 1'b1;
                        end
                        default:
                        begin
                            res.ok = 1'b0;
                        end
                    endcase
                    res.filled_count = count_next;
                    if (done)
                    begin
                        res_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occupied_reg <= '0;
            count_reg    <= '0;
            scan_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            occupied_reg <= occupied_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    // fill count tracks the occupancy bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(occupied_reg))
        else $error("fill count differs from occupied slots");

    // results only go out when the output register can take them
    a_res_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result issued into a full output register");

    // reads and writes never share a cycle, so no forwarding is needed
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> !mem_req.rd_en)
        else $error("memory read and write in the same cycle");

    // a new request is taken only after the previous result has been issued
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while one is in progress");

endmodule

/* design/typed_slot_table_with_counts.sv */
// ----------------------------------------------------------------------------
// typed_slot_table_with_counts
// typed slot table with fill count, first-free allocation and type search
// ----------------------------------------------------------------------------
// one transaction is handled at a time. add, remove, update, read, clear and
// the unused mode issue the slot memory read in the accept cycle; the exec
// state then decides and writes back once the output register is free. find
// and check walk the slot memory one slot per cycle from slot 0 while the
// output register is free, stopping at the first match or the last slot.
// s_tready rises again the cycle after the result is loaded into the output
// register; a result waiting there does not stop the next transaction from
// being accepted, only from finishing. the single registered read port of
// the contents memory sets this pacing. occupancy lives in flip-flops
// cleared by reset, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module typed_slot_table_with_counts
    import stc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // item_type[7:0], slot_index[11:8], amount[28:12], zero pad
    input  logic [2:0]   s_tuser,   // mode[2:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata    // ok[0], slot_found[4:1], slot_type[12:5],
                                    // slot_amount[28:13], slot_full[29],
                                    // filled_count[34:30], zero pad
);

    req_t      req;
    res_t      res;
    logic      res_valid;
    logic      out_free;
    mem_req_t  mem_req;
    entry_t    rd_data;

    res_t      m_res_reg;
    logic      m_tvalid_reg;

    // unpack the request transaction
    assign req.mode       = mode_t'(s_tuser[MODE_BITS-1:0]);
    assign req.item_type  = s_tdata[TYPE_BITS-1:0];
    assign req.slot_index = s_tdata[TYPE_BITS +: INDEX_BITS];
    assign req.amount     = s_tdata[TYPE_BITS + INDEX_BITS +: AMOUNT_IN_BITS];

    // output register frees up when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    stc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    stc_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // pack the result transaction, first field lowest
    assign m_tdata = {5'b0,
                      m_res_reg.filled_count,
                      m_res_reg.slot_full,
                      m_res_reg.slot_amount,
                      m_res_reg.slot_type,
                      m_res_reg.slot_found,
                      m_res_reg.ok};

endmodule
